// File: rtl/core/spn16_block_encrypt_core_assert.svh
// ----------------------------------------------------------------------------
// spn16 block encrypt core assertion macros
// concurrent property wrappers used by the port checker
// ----------------------------------------------------------------------------
`ifndef SPN16_BLOCK_ENCRYPT_CORE_ASSERT_SVH
`define SPN16_BLOCK_ENCRYPT_CORE_ASSERT_SVH

// overlapping implication, checked out of reset
`define SPN16_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("spn16 core: assertion failed");

// non-overlapping implication, checked out of reset
`define SPN16_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("spn16 core: assertion failed");

`endif

// File: rtl/core/spn16_pkg.sv
// ----------------------------------------------------------------------------
// spn16 package
// widths, s-box table and round helpers for the 16-bit spn cipher
// ----------------------------------------------------------------------------
package spn16_pkg;

	localparam int unsigned BLOCK_W  = 16;
	localparam int unsigned KEY_W    = 32;
	localparam int unsigned NIBBLE_W = 4;
	localparam int unsigned NIBBLES  = BLOCK_W / NIBBLE_W;
	localparam int unsigned FULL_RNDS = 3;
	localparam int unsigned RKEY_STEP = 4;

	typedef logic [BLOCK_W-1:0] block_t;
	typedef logic [KEY_W-1:0]   key_t;
	typedef logic [NIBBLE_W-1:0] nibble_t;

	// 4-bit substitution table
	localparam nibble_t SBOX [16] = '{
		4'h7, 4'hC, 4'h4, 4'hA, 4'hB, 4'h6, 4'hD, 4'h0,
		4'h2, 4'h5, 4'hF, 4'h9, 4'h8, 4'h3, 4'h1, 4'hE
	};

	// round key r is key bits 4r+15 down to 4r
	function automatic block_t round_key(input key_t key, input int unsigned r);
		round_key = key[RKEY_STEP*r +: BLOCK_W];
	endfunction

	// s-box on every nibble
	function automatic block_t substitute(input block_t v);
		block_t o;
		o = '0;
		for (int i = 0; i < NIBBLES; i++) begin
			o[NIBBLE_W*i +: NIBBLE_W] = SBOX[v[NIBBLE_W*i +: NIBBLE_W]];
		end
		substitute = o;
	endfunction

	// bit j of nibble i moves to bit i of nibble j
	function automatic block_t transpose(input block_t v);
		block_t o;
		o = '0;
		for (int i = 0; i < NIBBLES; i++) begin
			for (int j = 0; j < NIBBLE_W; j++) begin
				o[NIBBLE_W*j + i] = v[NIBBLE_W*i + j];
			end
		end
		transpose = o;
	endfunction

endpackage

// File: rtl/core/spn16_enc_logic.sv
// ----------------------------------------------------------------------------
// spn16 encryption logic
// four substitution rounds and the final key whitening, combinational
// ----------------------------------------------------------------------------
module spn16_enc_logic (
	input  spn16_pkg::key_t   key,
	input  spn16_pkg::block_t din,
	output spn16_pkg::block_t dout
);
	import spn16_pkg::*;

	block_t state;

	// three full rounds, then key xor and s-box, then whitening
	always_comb begin
		state = din;
		for (int unsigned r = 0; r < FULL_RNDS; r++) begin
			state = transpose(substitute(state ^ round_key(key, r)));
		end
		state = substitute(state ^ round_key(key, FULL_RNDS));
		dout  = state ^ round_key(key, FULL_RNDS + 1);
	end

endmodule

// File: rtl/core/spn16_block_encrypt_core.sv
// ----------------------------------------------------------------------------
// spn16 block encrypt core
// 16-bit substitution-permutation block cipher under a 32-bit key register
// ----------------------------------------------------------------------------
// usage:
//   a request is taken on a rising edge with start high and busy low;
//   plain_block is captured with it into the input register; done then pulses
//   for one cycle from the result register with cipher_block valid alongside it.
//   the path runs: input register, cipher rounds, result register.
//   throughput is one block per cycle while busy is low; the whole cipher
//   sits between the input and result registers, so back-to-back requests flow.
//   the key is written through cfg_valid / cfg_ready / cfg_data; cfg_ready
//   is always high. write the key only while no request is in flight.
//   reset clears the key to zero and drops all pending requests; busy is
//   high for the first cycle after reset and low from then on.
//   the receiver cannot stall: done is a one-cycle strobe and must be taken.
// ----------------------------------------------------------------------------
module spn16_block_encrypt_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  spn16_pkg::block_t plain_block,
	output logic              done,
	output spn16_pkg::block_t cipher_block,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  spn16_pkg::key_t   cfg_data
);
	import spn16_pkg::*;

	logic   init_q;
	key_t   key_q;
	logic   valid_s1;
	block_t block_s1;
	block_t enc_out;
	logic   done_q;
	block_t cipher_q;
	logic   req_acc;

	assign busy      = !init_q;
	assign cfg_ready = 1'b1;
	assign req_acc   = start && !busy;

	// out-of-reset marker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= 1'b0;
		end else begin
			init_q <= 1'b1;
		end
	end

	// key register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			key_q <= cfg_data;
		end
	end

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= req_acc;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (req_acc) begin
			block_s1 <= plain_block;
		end
	end

	spn16_enc_logic u_enc (
		.key  (key_q),
		.din  (block_s1),
		.dout (enc_out)
	);

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			cipher_q <= enc_out;
		end
	end

	assign done         = done_q;
	assign cipher_block = cipher_q;

endmodule

// File: rtl/core/spn16_chk.sv
// ----------------------------------------------------------------------------
// spn16 port checker
// request to result timing seen on the core's ports
// ----------------------------------------------------------------------------
`include "spn16_block_encrypt_core_assert.svh"

module spn16_chk (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// every accepted request gives a result later on
	`SPN16_ASSERT_NOW(a_req_to_done, clk, arst_n, start && !busy, ##2 done)

	// no result without an earlier accepted request
	`SPN16_ASSERT_NOW(a_done_has_req, clk, arst_n, done, $past(start && !busy, 2))

	// busy is high only straight after reset and low from then on
	`SPN16_ASSERT_NEXT(a_busy_once, clk, arst_n, 1'b1, !busy)

endmodule

bind spn16_block_encrypt_core spn16_chk u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

// File: dv/tb_spn16_block_encrypt_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spn16 block encrypt core testbench
// plaintext blocks under a series of cipher keys, each ciphertext predicted
// in software and checked against the oldest pending request on every done
// strobe; directed blocks and keys first, then random phases with key changes
// ----------------------------------------------------------------------------
module tb_spn16_block_encrypt_core;

	import spn16_pkg::*;

	localparam int unsigned CLK_PERIOD    = 10;
	localparam int unsigned RESET_CYCLES  = 12;
	localparam int unsigned DRAIN_CYCLES  = 4;
	localparam int unsigned STALL_LIMIT   = 1000;
	localparam int unsigned RANDOM_BLOCKS = 1325;

	// pending ciphertext, with what produced it for the mismatch report
	typedef struct packed {
		block_t plain;
		key_t   key;
		block_t cipher;
	} cipher_exp_t;

	// s-box of the cipher
	localparam logic [3:0] SBOX_LUT [16] = '{
		4'h7, 4'hC, 4'h4, 4'hA, 4'hB, 4'h6, 4'hD, 4'h0,
		4'h2, 4'h5, 4'hF, 4'h9, 4'h8, 4'h3, 4'h1, 4'hE
	};

	logic   clk;
	logic   arst_n;
	logic   start;
	logic   busy;
	block_t plain_block;
	logic   done;
	block_t cipher_block;
	logic   cfg_valid;
	logic   cfg_ready;
	key_t   cfg_data;

	key_t        model_key;
	cipher_exp_t cipher_q[$];
	int unsigned mismatch_cnt;
	int unsigned idle_cycles;
	bit          burst_mode;

	spn16_block_encrypt_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.plain_block  (plain_block),
		.done         (done),
		.cipher_block (cipher_block),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// cipher prediction
	// ------------------------------------------------------------------------
	function automatic block_t sbox_layer(input block_t v);
		block_t o;
		for (int n = 0; n < 4; n++) begin
			o[4*n +: 4] = SBOX_LUT[v[4*n +: 4]];
		end
		return o;
	endfunction

	// bit j of nibble i goes to bit i of nibble j
	function automatic block_t bit_transpose(input block_t v);
		block_t o;
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				o[4*j + i] = v[4*i + j];
			end
		end
		return o;
	endfunction

	function automatic block_t predict_cipher_block(input key_t k, input block_t pt);
		block_t s;
		s = pt;
		for (int r = 0; r < 3; r++) begin
			s = bit_transpose(sbox_layer(s ^ k[4*r +: 16]));
		end
		s = sbox_layer(s ^ k[12 +: 16]);
		return s ^ k[16 +: 16];
	endfunction

	// ------------------------------------------------------------------------
	// request driving
	// ------------------------------------------------------------------------
	// mostly back to back, some short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(99);
		if (burst_mode) return 0;
		if (roll < 60) return 0;
		if (roll < 90) return $urandom_range(3, 1);
		if (roll < 98) return $urandom_range(10, 4);
		return $urandom_range(40, 20);
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_block(input block_t pt);
		int unsigned gap;
		cipher_exp_t e;
		gap = pick_gap();
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) begin
				plain_block = block_t'($urandom);
				@(negedge clk);
			end
		end
		start       = 1'b1;
		plain_block = pt;
		do @(posedge clk); while (busy);
		e.plain  = pt;
		e.key    = model_key;
		e.cipher = predict_cipher_block(model_key, pt);
		cipher_q.push_back(e);
		@(negedge clk);
	endtask

	// key write, only with nothing in flight
	task automatic write_key(input key_t k);
		start = 1'b0;
		while (cipher_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = k;
		do @(posedge clk); while (!cfg_ready);
		model_key = k;
		@(negedge clk);
		cfg_valid = 1'b0;
		cfg_data  = key_t'($urandom);
	endtask

	function automatic key_t pick_key();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 4) return 32'h0000_0000;
		if (roll < 8) return 32'hFFFF_FFFF;
		if (roll < 11) return 32'h0000_FFFF;
		if (roll < 14) return 32'hFFFF_0000;
		if (roll < 17) return key_t'(1) << $urandom_range(31);
		return key_t'($urandom);
	endfunction

	// ------------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		cipher_exp_t e;
		if (arst_n && done) begin
			if (cipher_q.size() == 0) begin
				mismatch_cnt++;
				$display("%0t: unexpected done, cipher_block %h", $time, cipher_block);
			end else begin
				e = cipher_q.pop_front();
				if (cipher_block !== e.cipher) begin
					mismatch_cnt++;
					$display("%0t: cipher_block mismatch (plain %h key %h): expected %h, actual %h",
						$time, e.plain, e.key, e.cipher, cipher_block);
				end
			end
		end
	end

	// stall watchdog
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready) || !arst_n) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------
	// encryption with the key still at its reset value
	task automatic test_reset_key();
		send_block(16'h0000);
		send_block(16'hFFFF);
		send_block(16'h0001);
		send_block(16'h8000);
	endtask

	// extreme and patterned keys
	task automatic test_key_extremes();
		write_key(32'hFFFF_FFFF);
		send_block(16'h0000);
		write_key(32'hAAAA_AAAA);
		send_block(16'h5555);
		write_key(32'h5555_5555);
		send_block(16'hAAAA);
		write_key(32'h0000_FFFF);
		send_block(16'hFFFF);
		write_key(32'hFFFF_0000);
		send_block(16'h1234);
	endtask

	// every s-box input in every nibble position, back to back
	task automatic test_sbox_inputs();
		write_key(32'h3A94_D63F);
		burst_mode = 1'b1;
		for (int n = 0; n < 16; n++) begin
			send_block(block_t'(n * 16'h1111));
		end
		burst_mode = 1'b0;
	endtask

	// random blocks in phases, new key and idling style per phase
	task automatic test_random_traffic();
		int unsigned sent;
		int unsigned phase_len;
		sent = 0;
		while (sent < RANDOM_BLOCKS) begin
			write_key(pick_key());
			burst_mode = ($urandom_range(3) == 0);
			phase_len  = $urandom_range(120, 10);
			for (int i = 0; i < phase_len; i++) begin
				send_block(block_t'($urandom));
			end
			sent += phase_len;
		end
		burst_mode = 1'b0;
	endtask

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		plain_block  = '0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		model_key    = '0;
		mismatch_cnt = 0;
		idle_cycles  = 0;
		burst_mode   = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		test_reset_key();
		test_key_extremes();
		test_sbox_inputs();
		test_random_traffic();

		// drain outstanding requests
		start = 1'b0;
		while (cipher_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatch_cnt == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
